FILE: rtl/core/mount_angle_to_encoder_count_macros.svh
// Assertion macros used by the mount angle to encoder count RTL
`ifndef MOUNT_ANGLE_TO_ENCODER_COUNT_MACROS_SVH
`define MOUNT_ANGLE_TO_ENCODER_COUNT_MACROS_SVH

// Implication checked on every rising edge outside reset
`define MAEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset
`define MAEC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/core/maec_pkg.sv
// Types and constants for the mount angle to encoder count block
`default_nettype none
package maec_pkg;

  // Internal count width: limits, turn and fold offsets all fit with margin
  localparam int unsigned CW = 36;
  // Bits of the dividend magnitude fed to the remainder pipeline
  localparam int unsigned DivBits = 33;
  // Cycles from an accepted item to its result strobe
  localparam int unsigned Latency = 41;

  typedef enum logic [2:0] {
    RegZeroOffset = 3'd0,
    RegCntPerRad  = 3'd1,
    RegCntPerTurn = 3'd2,
    RegLimitLow   = 3'd3,
    RegLimitHigh  = 3'd4,
    RegWrapMode   = 3'd5
  } reg_addr_e;

  typedef enum logic [1:0] {
    WrapNone = 2'd0,
    WrapAdd  = 2'd1,
    WrapSub  = 2'd2
  } wrap_mode_e;

  typedef struct packed {
    logic signed [31:0] target_angle;
    logic signed [31:0] target_rate;
    logic signed [31:0] present_count;
    logic               skip_wrap;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] command_count;
    logic signed [31:0] command_rate;
    logic               uncalibrated;
  } out_item_t;

  // Side data that rides along with the count through the fold stages
  typedef struct packed {
    logic signed [CW-1:0] cnt;
    logic signed [CW-1:0] ref_v;
    logic signed [31:0]   cur;
    logic signed [31:0]   rate;
    logic                 dneg;
    logic                 dgt;
    logic                 span;
    logic                 skip;
  } fold_pay_t;

endpackage
`default_nettype wire

FILE: rtl/core/mount_angle_to_encoder_count.sv
// Mount angle to encoder count converter, top level with register file
//
// One item enters per clock; busy_o never rises. Each result appears on
// out_item_o with done_o high, in order. Each item passes through the
// multiply, round and limit stages around the remainder pipeline (one
// quotient bit per stage, 33 stages) that folds the count into a turn.
// Registers must be written only while no item is in flight; there is no
// clearing pass after reset.
`default_nettype none
`include "mount_angle_to_encoder_count_macros.svh"
module mount_angle_to_encoder_count (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire maec_pkg::in_item_t   in_item_i,
  output logic                      done_o,
  output maec_pkg::out_item_t       out_item_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import maec_pkg::*;

  // ---------------- register file ----------------
  logic signed [31:0] zero_q, lim_a_q, lim_b_q;
  logic [31:0]        cpr_q;
  logic [30:0]        cpt_q;
  logic [1:0]         wrap_q;
  reg_addr_e          addr;
  logic               wr_en;

  assign pready = 1'b1;
  assign addr   = reg_addr_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q  <= '0;
      cpr_q   <= '0;
      cpt_q   <= '0;
      lim_a_q <= '0;
      lim_b_q <= '0;
      wrap_q  <= '0;
    end else if (wr_en) begin
      case (addr)
        RegZeroOffset: zero_q  <= pwdata;
        RegCntPerRad:  cpr_q   <= pwdata;
        RegCntPerTurn: cpt_q   <= pwdata[30:0];
        RegLimitLow:   lim_a_q <= pwdata;
        RegLimitHigh:  lim_b_q <= pwdata;
        RegWrapMode:   wrap_q  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (addr)
      RegZeroOffset: prdata = zero_q;
      RegCntPerRad:  prdata = cpr_q;
      RegCntPerTurn: prdata = {1'b0, cpt_q};
      RegLimitLow:   prdata = lim_a_q;
      RegLimitHigh:  prdata = lim_b_q;
      RegWrapMode:   prdata = {30'b0, wrap_q};
      default:       prdata = '0;
    endcase
  end

  // Derived config values; the user must keep them static while items are in flight, the block does not enforce it
  logic signed [CW-1:0] lo, hi, t_s;
  logic                 uncal;
  assign lo    = (lim_a_q <= lim_b_q) ? CW'(lim_a_q) : CW'(lim_b_q);
  assign hi    = (lim_a_q <= lim_b_q) ? CW'(lim_b_q) : CW'(lim_a_q);
  assign t_s   = CW'(signed'({1'b0, cpt_q}));
  assign uncal = (cpt_q == '0);

  assign busy_o = 1'b0;
  logic accept;
  assign accept = start_i & ~busy_o;

  // ---------------- stage A: offset sum, magnitudes, rate gain ----------------
  logic               vld_a_q;
  logic [32:0]        msum_a_q;
  logic               sneg_a_q, rneg_a_q, skip_a_q;
  logic [31:0]        mr_a_q;
  logic [33:0]        k_a_q;
  logic signed [31:0] cur_a_q;
  logic signed [33:0] sum_a;
  logic [41:0]        k_full;

  assign sum_a  = 34'(zero_q) + 34'(in_item_i.target_angle);
  assign k_full = 42'(cpr_q) * 42'd1000 + 42'd128;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_a_q <= 1'b0;
    else         vld_a_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    msum_a_q <= sum_a[33] ? 33'(-sum_a) : sum_a[32:0];
    sneg_a_q <= sum_a[33];
    mr_a_q   <= in_item_i.target_rate[31] ? 32'(-in_item_i.target_rate)
                                          : 32'(in_item_i.target_rate);
    rneg_a_q <= in_item_i.target_rate[31];
    k_a_q    <= k_full[41:8];
    cur_a_q  <= in_item_i.present_count;
    skip_a_q <= in_item_i.skip_wrap;
  end

  // ---------------- stage B: products ----------------
  logic               vld_b_q, sneg_b_q, rneg_b_q, skip_b_q;
  logic [64:0]        prod_b_q;
  logic [63:0]        rlo_b_q, mlo;
  logic [33:0]        rhi_b_q;
  logic signed [31:0] cur_b_q;

  assign mlo = msum_a_q[31:0] * cpr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_b_q <= 1'b0;
    else         vld_b_q <= vld_a_q;
  end

  always_ff @(posedge clk_i) begin
    prod_b_q <= {1'b0, mlo} + (msum_a_q[32] ? {1'b0, cpr_q, 32'b0} : 65'd0);
    rlo_b_q  <= mr_a_q * k_a_q[31:0];
    rhi_b_q  <= 34'(mr_a_q) * 34'(k_a_q[33:32]);
    sneg_b_q <= sneg_a_q;
    rneg_b_q <= rneg_a_q;
    cur_b_q  <= cur_a_q;
    skip_b_q <= skip_a_q;
  end

  // ---------------- stage C: round count, scale and clamp rate ----------------
  logic                 vld_c_q, skip_c_q;
  logic signed [CW-1:0] cnt_c_q;
  logic signed [31:0]   rate_c_q, cur_c_q;
  logic [35:0]          rem_c;
  logic                 up_c;
  logic [29:0]          mag_c;
  logic [65:0]          rfull;
  logic [37:0]          tr_c;
  logic [31:0]          trs_c;

  assign rem_c = prod_b_q[35:0];
  assign up_c  = sneg_b_q ? (rem_c > 36'h8_0000_0000) : (rem_c >= 36'h8_0000_0000);
  assign mag_c = 30'(prod_b_q[64:36]) + 30'(up_c);
  assign rfull = {2'b0, rlo_b_q} + {rhi_b_q, 32'b0};
  assign tr_c  = rfull[65:28];
  assign trs_c = (tr_c > 38'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : tr_c[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_c_q <= 1'b0;
    else         vld_c_q <= vld_b_q;
  end

  always_ff @(posedge clk_i) begin
    cnt_c_q  <= sneg_b_q ? -CW'(signed'({1'b0, mag_c})) : CW'(signed'({1'b0, mag_c}));
    rate_c_q <= rneg_b_q ? -signed'(trs_c) : signed'(trs_c);
    cur_c_q  <= cur_b_q;
    skip_c_q <= skip_b_q;
  end

  // ---------------- stage D: pick fold reference, load remainder pipe ----------------
  logic                 span_d;
  logic signed [CW-1:0] ref_d, d_d, md_d;
  fold_pay_t            pay_d;

  assign span_d = (hi - lo) < t_s;
  assign ref_d  = span_d ? lo : CW'(cur_c_q);
  assign d_d    = cnt_c_q - ref_d;
  assign md_d   = d_d[CW-1] ? -d_d : d_d;

  always_comb begin
    pay_d       = '0;
    pay_d.cnt   = cnt_c_q;
    pay_d.ref_v = ref_d;
    pay_d.cur   = cur_c_q;
    pay_d.rate  = rate_c_q;
    pay_d.dneg  = d_d[CW-1];
    pay_d.dgt   = d_d > t_s;
    pay_d.span  = span_d;
    pay_d.skip  = skip_c_q;
  end

  // ---------------- remainder pipeline: |d| mod t, one bit per stage ----------------
  logic              dv_vld_q [DivBits+1];
  logic [DivBits-1:0] dv_dvd_q [DivBits+1];
  logic [31:0]       dv_rem_q [DivBits+1];
  fold_pay_t         dv_pay_q [DivBits+1];
  logic [31:0]       dv_sh    [DivBits];
  logic [31:0]       dv_nx    [DivBits];

  always_comb begin
    for (int j = 0; j < DivBits; j++) begin
      dv_sh[j] = {dv_rem_q[j][30:0], dv_dvd_q[j][DivBits-1]};
      dv_nx[j] = (dv_sh[j] >= {1'b0, cpt_q}) ? dv_sh[j] - {1'b0, cpt_q} : dv_sh[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= DivBits; j++) dv_vld_q[j] <= 1'b0;
    end else begin
      dv_vld_q[0] <= vld_c_q;
      for (int j = 1; j <= DivBits; j++) dv_vld_q[j] <= dv_vld_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_dvd_q[0] <= md_d[DivBits-1:0];
    dv_rem_q[0] <= '0;
    dv_pay_q[0] <= pay_d;
    for (int j = 1; j <= DivBits; j++) begin
      dv_dvd_q[j] <= {dv_dvd_q[j-1][DivBits-2:0], 1'b0};
      dv_rem_q[j] <= dv_nx[j-1];
      dv_pay_q[j] <= dv_pay_q[j-1];
    end
  end

  // ---------------- stage F: apply the fold ----------------
  logic                 vld_f_q;
  fold_pay_t            pay_f_q;
  logic signed [CW-1:0] r_f, v_f;
  fold_pay_t            pin_f;
  fold_pay_t            nxt_f;

  assign pin_f = dv_pay_q[DivBits];
  assign r_f   = CW'(signed'(dv_rem_q[DivBits]));

  always_comb begin
    if (pin_f.dneg)     v_f = pin_f.ref_v - r_f + t_s;
    else if (pin_f.dgt) v_f = pin_f.ref_v + r_f;
    else                v_f = pin_f.cnt;
  end

  always_comb begin
    nxt_f     = pin_f;
    nxt_f.cnt = v_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_f_q <= 1'b0;
    else         vld_f_q <= dv_vld_q[DivBits];
  end

  always_ff @(posedge clk_i) begin
    pay_f_q <= nxt_f;
  end

  // ---------------- stage G: snap to limits, or pick nearest turn ----------------
  logic                 vld_g_q;
  fold_pay_t            pay_g_q;
  logic signed [CW-1:0] v_g, c_g;
  fold_pay_t            nxt_g;

  assign c_g = pay_f_q.cnt;

  always_comb begin
    if (pay_f_q.span) begin
      if (c_g > hi) v_g = ((c_g - hi) < (lo - (c_g - t_s))) ? hi : lo;
      else          v_g = c_g;
    end else begin
      v_g = ((c_g - CW'(pay_f_q.cur)) > (t_s >>> 1)) ? c_g - t_s : c_g;
    end
  end

  always_comb begin
    nxt_g     = pay_f_q;
    nxt_g.cnt = v_g;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_g_q <= 1'b0;
    else         vld_g_q <= vld_f_q;
  end

  always_ff @(posedge clk_i) begin
    pay_g_q <= nxt_g;
  end

  // ---------------- stage H: shift back inside the limits ----------------
  logic                 vld_h_q;
  fold_pay_t            pay_h_q;
  logic signed [CW-1:0] v_h, c_h;
  fold_pay_t            nxt_h;

  assign c_h = pay_g_q.cnt;

  always_comb begin
    if (pay_g_q.span)  v_h = c_h;
    else if (c_h < lo) v_h = c_h + t_s;
    else if (c_h > hi) v_h = c_h - t_s;
    else               v_h = c_h;
  end

  always_comb begin
    nxt_h     = pay_g_q;
    nxt_h.cnt = v_h;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_h_q <= 1'b0;
    else         vld_h_q <= vld_g_q;
  end

  always_ff @(posedge clk_i) begin
    pay_h_q <= nxt_h;
  end

  // ---------------- stage I: wrap mode, saturate, output register ----------------
  logic signed [CW-1:0] c_i, v_i;
  logic signed [31:0]   sat_i;
  logic                 done_q;
  out_item_t            out_q;

  assign c_i = pay_h_q.cnt;

  always_comb begin
    v_i = c_i;
    if (!pay_h_q.skip) begin
      case (wrap_q)
        WrapAdd: if ((c_i + t_s) < hi) v_i = c_i + t_s;
        WrapSub: if ((c_i - t_s) > lo) v_i = c_i - t_s;
        default: v_i = c_i;
      endcase
    end
    if (v_i > CW'(32'sh7FFF_FFFF))      sat_i = 32'sh7FFF_FFFF;
    else if (v_i < CW'(32'sh8000_0000)) sat_i = 32'sh8000_0000;
    else                                sat_i = v_i[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= vld_h_q;
  end

  always_ff @(posedge clk_i) begin
    if (uncal) begin
      out_q.command_count <= '0;
      out_q.command_rate  <= '0;
      out_q.uncalibrated  <= 1'b1;
    end else begin
      out_q.command_count <= sat_i;
      out_q.command_rate  <= pay_h_q.rate;
      out_q.uncalibrated  <= 1'b0;
    end
  end

  assign done_o     = done_q;
  assign out_item_o = out_q;

  // ---------------- assertions ----------------
  `MAEC_ASSERT_IMP(a_latency, accept, ##Latency done_o, "result strobe missing after latency")
  `MAEC_ASSERT_IMP(a_uncal_zero, done_o && out_item_o.uncalibrated,
                   out_item_o.command_count == 0 && out_item_o.command_rate == 0,
                   "uncalibrated result carries nonzero fields")
  `MAEC_ASSERT_NEVER(a_rate_sat, done_o && out_item_o.command_rate == -32'sh8000_0000,
                     "rate escaped saturation")
  `MAEC_ASSERT_NEVER(a_busy, busy_o, "busy raised on a fully pipelined path")

endmodule
`default_nettype wire
